// File: rtl/chebyshev_series_evaluator_defines.svh
// ----------------------------------------------------------------------------
// Chebyshev series evaluator: assertion macros
// Concurrent assertion wrappers on clk with rst_n; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef CHEBYSHEV_SERIES_EVALUATOR_DEFINES_SVH
`define CHEBYSHEV_SERIES_EVALUATOR_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define CSE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cse: assertion failed");

// next-cycle implication
`define CSE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cse: assertion failed");

`else

`define CSE_ASSERT_NOW(lbl, ante, cons)
`define CSE_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: rtl/cse_pkg.sv
// ----------------------------------------------------------------------------
// cse_pkg
// Shared widths, codes and the controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
package cse_pkg;

  // field widths
  localparam int TC_W    = 7;
  localparam int IDX_W   = 6;
  localparam int COEF_W  = 32;
  localparam int POINT_W = 18;
  localparam int TERM_W  = 48;
  localparam int SPLIT_W = 24;
  localparam int MUL_W   = POINT_W + SPLIT_W + 1;

  localparam logic [TC_W-1:0] TC_RESET = TC_W'(1);

  // operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  // saturation bounds
  localparam logic signed [TERM_W-1:0] TERM_MAX = {1'b0, {(TERM_W-1){1'b1}}};
  localparam logic signed [TERM_W-1:0] TERM_MIN = {1'b1, {(TERM_W-1){1'b0}}};
  localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

  // datapath commands
  typedef struct packed {
    logic start;
    logic ld_u1;
    logic ld_u2;
    logic t_ld;
    logic mul_lo;
    logic mul_hi;
    logic prod;
    logic acc;
    logic out_ld;
    logic single;
  } cse_cmd_t;

endpackage

// File: rtl/cse_ram.sv
// ----------------------------------------------------------------------------
// cse_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/cse_ctrl.sv
// ----------------------------------------------------------------------------
// cse_ctrl
// Sequencer for the Clenshaw recurrence: handshakes, term count register,
// coefficient store addressing and datapath commands.
// ----------------------------------------------------------------------------
module cse_ctrl #(
  parameter int MAX_TERMS = 64,
  localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [cse_pkg::TC_W-1:0]  cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_operation,
  input  logic [cse_pkg::IDX_W-1:0] in_coef_index,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      ram_we,
  output logic [AW-1:0]             ram_waddr,
  output logic                      ram_re,
  output logic [AW-1:0]             ram_raddr,
  output cse_pkg::cse_cmd_t         cmd
);
  import cse_pkg::*;

  localparam int CW = ($clog2(MAX_TERMS + 1) > TC_W) ? $clog2(MAX_TERMS + 1) : TC_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LD1  = 3'd1;
  localparam logic [2:0] S_LD2  = 3'd2;
  localparam logic [2:0] S_MLO  = 3'd3;
  localparam logic [2:0] S_MHI  = 3'd4;
  localparam logic [2:0] S_PROD = 3'd5;
  localparam logic [2:0] S_ACC  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]      state_r, state_nxt;
  logic [TC_W-1:0] term_count_r;
  logic [CW-1:0]   n_r, n_nxt, k_r, k_nxt;
  logic [CW-1:0]   tc_w, n_eff, idx_w;
  logic [CW-1:0]   a_first, a_second, a_third, k_dec;
  logic            final_r, final_nxt;
  logic            single_r, single_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            accept;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  // effective term count, clamped to 1..MAX_TERMS
  assign tc_w = CW'(term_count_r);
  always_comb begin
    priority if (tc_w == '0) begin
      n_eff = CW'(1);
    end else if (tc_w > CW'(MAX_TERMS)) begin
      n_eff = CW'(MAX_TERMS);
    end else begin
      n_eff = tc_w;
    end
  end

  // coefficient load, out-of-range index dropped
  assign idx_w     = CW'(in_coef_index);
  assign ram_we    = accept && (in_operation == OP_LOAD) && (idx_w < CW'(MAX_TERMS));
  assign ram_waddr = idx_w[AW-1:0];

  // read addresses
  assign a_first  = n_eff - CW'(1);
  assign a_second = n_r - CW'(2);
  assign a_third  = n_r - CW'(3);
  assign k_dec    = k_r - CW'(1);

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    n_nxt      = n_r;
    k_nxt      = k_r;
    final_nxt  = final_r;
    single_nxt = single_r;
    ram_re     = 1'b0;
    ram_raddr  = '0;
    cmd        = '0;
    cmd.single = single_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_operation == OP_EVAL)) begin
          cmd.start  = 1'b1;
          n_nxt      = n_eff;
          single_nxt = 1'b0;
          final_nxt  = 1'b0;
          ram_re     = 1'b1;
          ram_raddr  = a_first[AW-1:0];
          state_nxt  = S_LD1;
        end
      end
      S_LD1: begin
        cmd.ld_u1 = 1'b1;
        if (n_r == CW'(1)) begin
          single_nxt = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = a_second[AW-1:0];
          state_nxt = S_LD2;
        end
      end
      S_LD2: begin
        cmd.ld_u2 = 1'b1;
        if (n_r == CW'(2)) begin
          final_nxt = 1'b1;
        end else begin
          k_nxt     = a_third;
          ram_re    = 1'b1;
          ram_raddr = a_third[AW-1:0];
        end
        state_nxt = S_MLO;
      end
      S_MLO: begin
        cmd.mul_lo = 1'b1;
        cmd.t_ld   = !final_r;
        state_nxt  = S_MHI;
      end
      S_MHI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_PROD;
      end
      S_PROD: begin
        cmd.prod  = 1'b1;
        state_nxt = final_r ? S_DONE : S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (k_r == '0) begin
          final_nxt = 1'b1;
        end else begin
          k_nxt     = k_dec;
          ram_re    = 1'b1;
          ram_raddr = k_dec[AW-1:0];
        end
        state_nxt = S_MLO;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
    endcase
  end

  // output beat holding
  always_comb begin
    priority if (cmd.out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      term_count_r <= TC_RESET;
      n_r          <= '0;
      k_r          <= '0;
      final_r      <= 1'b0;
      single_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      k_r         <= k_nxt;
      final_r     <= final_nxt;
      single_r    <= single_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        term_count_r <= cfg_wdata;
      end
    end
  end

endmodule

// File: rtl/cse_datapath.sv
// ----------------------------------------------------------------------------
// cse_datapath
// Running terms, shared split multiplier, saturating adders and the result
// register for the Clenshaw recurrence.
// ----------------------------------------------------------------------------
module cse_datapath #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  cse_pkg::cse_cmd_t                  cmd,
  input  logic signed [cse_pkg::POINT_W-1:0] in_point,
  input  logic                               in_batch_last,
  input  logic signed [cse_pkg::COEF_W-1:0]  coef_rd,
  output logic signed [cse_pkg::COEF_W-1:0]  out_series_value,
  output logic                               out_overflow,
  output logic                               out_last
);
  import cse_pkg::*;

  localparam int PROD_W = MUL_W + 1 + SPLIT_W - FRAC_BITS;
  localparam int SUM_W  = ((PROD_W + 1 > TERM_W) ? PROD_W + 1 : TERM_W) + 1;

  logic signed [POINT_W-1:0]   x_r;
  logic                        last_r;
  logic signed [TERM_W-1:0]    u1_r, u2_r, t_r;
  logic signed [TERM_W-1:0]    u1_nxt, t_nxt;
  logic signed [MUL_W-1:0]     p_lo_r, p_hi_r, mul_res;
  logic signed [SPLIT_W:0]     mul_opnd;
  logic signed [PROD_W-1:0]    prod_r, prod_nxt;
  logic signed [TERM_W:0]      t_diff;
  logic signed [SUM_W-1:0]     acc_sum, fin_sum;
  logic [SUM_W-TERM_W:0]       acc_top;
  logic [SUM_W-COEF_W:0]       fin_top;
  logic signed [COEF_W-1:0]    y_nxt;
  logic                        t_sat, acc_sat, y_sat;
  logic                        ovf_r, ovf_nxt;
  logic signed [COEF_W-1:0]    series_r;
  logic                        overflow_r, last_out_r;

  // shared multiplier: point times low or high half of u1
  assign mul_opnd = cmd.mul_hi ? $signed({u1_r[TERM_W-1], u1_r[TERM_W-1:SPLIT_W]})
                               : $signed({1'b0, u1_r[SPLIT_W-1:0]});
  assign mul_res  = x_r * mul_opnd;

  // recombine halves, floor shift by FRAC_BITS
  assign prod_nxt = (PROD_W'(p_hi_r) <<< (SPLIT_W - FRAC_BITS))
                  + PROD_W'(p_lo_r >>> FRAC_BITS);

  // t = c[k] - u1, saturated to term width
  assign t_diff = (TERM_W+1)'(coef_rd) - (TERM_W+1)'(u1_r);
  assign t_sat  = t_diff[TERM_W] ^ t_diff[TERM_W-1];
  assign t_nxt  = t_sat ? (t_diff[TERM_W] ? TERM_MIN : TERM_MAX) : t_diff[TERM_W-1:0];

  // u1 = u2 + 2*x*u1, saturated to term width
  assign acc_sum = SUM_W'(u2_r) + (SUM_W'(prod_r) <<< 1);
  assign acc_top = acc_sum[SUM_W-1:TERM_W-1];
  assign acc_sat = !((&acc_top) || !(|acc_top));
  assign u1_nxt  = acc_sat ? (acc_sum[SUM_W-1] ? TERM_MIN : TERM_MAX)
                           : acc_sum[TERM_W-1:0];

  // y = x*u1 + u2, saturated to result width
  assign fin_sum = SUM_W'(u2_r) + SUM_W'(prod_r);
  assign fin_top = fin_sum[SUM_W-1:COEF_W-1];
  assign y_sat   = !((&fin_top) || !(|fin_top));
  assign y_nxt   = y_sat ? (fin_sum[SUM_W-1] ? COEF_MIN : COEF_MAX)
                         : fin_sum[COEF_W-1:0];

  // sticky overflow for the current point
  assign ovf_nxt = cmd.start ? 1'b0
                 : (ovf_r || (cmd.t_ld && t_sat) || (cmd.acc && acc_sat));

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      x_r    <= in_point;
      last_r <= in_batch_last;
    end
    priority if (cmd.ld_u1) begin
      u1_r <= TERM_W'(coef_rd);
    end else if (cmd.acc) begin
      u1_r <= u1_nxt;
    end
    priority if (cmd.ld_u2) begin
      u2_r <= TERM_W'(coef_rd);
    end else if (cmd.acc) begin
      u2_r <= t_r;
    end
    if (cmd.t_ld) begin
      t_r <= t_nxt;
    end
    if (cmd.mul_lo) begin
      p_lo_r <= mul_res;
    end
    if (cmd.mul_hi) begin
      p_hi_r <= mul_res;
    end
    if (cmd.prod) begin
      prod_r <= prod_nxt;
    end
    ovf_r <= ovf_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      series_r   <= cmd.single ? u1_r[COEF_W-1:0] : y_nxt;
      overflow_r <= cmd.single ? 1'b0 : (ovf_r || y_sat);
      last_out_r <= last_r;
    end
  end

  assign out_series_value = series_r;
  assign out_overflow     = overflow_r;
  assign out_last         = last_out_r;

endmodule

// File: rtl/chebyshev_series_evaluator.sv
// ----------------------------------------------------------------------------
// chebyshev_series_evaluator
// Fixed-point Chebyshev series evaluation by Clenshaw's recurrence, with a
// coefficient store loaded through the input channel.
//
//   channel  direction  beat contents
//   in_      input      operation, coef_index, coef_value, point, batch_last
//   out_     output     series_value, overflow, last
//   cfg_     input      term_count write
//
// A load beat is written to the store as it is accepted. A point over n terms
// gives its result and frees the input in the same cycle; each term uses the
// one shared 18x25 multiplier twice, then a recombine and a saturating add.
// Reset is synchronous, active low; term_count returns to 1. The store is not
// cleared. A stalled result holds the sequencer in its last step; loads and
// a new point are taken only once it is back in idle.
// ----------------------------------------------------------------------------
`include "chebyshev_series_evaluator_defines.svh"

module chebyshev_series_evaluator #(
  parameter int MAX_TERMS = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [cse_pkg::TC_W-1:0]           cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_operation,
  input  logic [cse_pkg::IDX_W-1:0]          in_coef_index,
  input  logic signed [cse_pkg::COEF_W-1:0]  in_coef_value,
  input  logic signed [cse_pkg::POINT_W-1:0] in_point,
  input  logic                               in_batch_last,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [cse_pkg::COEF_W-1:0]  out_series_value,
  output logic                               out_overflow,
  output logic                               out_last
);
  import cse_pkg::*;

  localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

  cse_cmd_t              cmd;
  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [COEF_W-1:0]     ram_rdata;

  // sequencer
  cse_ctrl #(
    .MAX_TERMS (MAX_TERMS)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operation  (in_operation),
    .in_coef_index (in_coef_index),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_re        (ram_re),
    .ram_raddr     (ram_raddr),
    .cmd           (cmd)
  );

  // coefficient store
  cse_ram #(
    .WIDTH (COEF_W),
    .DEPTH (MAX_TERMS)
  ) u_coef_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (in_coef_value),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // arithmetic
  cse_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk              (clk),
    .cmd              (cmd),
    .in_point         (in_point),
    .in_batch_last    (in_batch_last),
    .coef_rd          ($signed(ram_rdata)),
    .out_series_value (out_series_value),
    .out_overflow     (out_overflow),
    .out_last         (out_last)
  );

  // checks
  `CSE_ASSERT_NEXT(a_eval_leaves_idle, in_valid && in_ready && (in_operation == OP_EVAL), !in_ready)
  `CSE_ASSERT_NEXT(a_load_stays_idle, in_valid && in_ready && (in_operation == OP_LOAD), in_ready)
  `CSE_ASSERT_NOW(a_result_slot_free, cmd.out_ld, !out_valid || out_ready)
  `CSE_ASSERT_NOW(a_no_load_while_busy, ram_we, in_ready && !ram_re)
  `CSE_ASSERT_NEXT(a_result_shown, cmd.out_ld, out_valid && in_ready)

endmodule
